FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/mtsl_pkg.sv
// ----------------------------------------------------------------------------
// mtsl_pkg
// Constants, codes and types shared by the sorted-list merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsl_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int FUNC_W = 2;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH_A,
    OP_PUSH_B,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/mtsl_ifs.sv
// ----------------------------------------------------------------------------
// mtsl stream interfaces
// Valid/ready channels for input items and merged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtsl_item_if import mtsl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface mtsl_result_if import mtsl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last;
  logic                     overflow;

  modport source (output valid, output merged_value, output last, output overflow,
                  input ready);
  modport sink   (input valid, input merged_value, input last, input overflow,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mtsl_ram.sv
// ----------------------------------------------------------------------------
// mtsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsl_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/mtsl_front.sv
// ----------------------------------------------------------------------------
// mtsl_front
// Accepts input items and turns them into queued commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsl_front import mtsl_pkg::*; (
  mtsl_item_if.sink item,
  output logic      enq_valid,
  input  wire logic enq_ready,
  output cmd_t      enq_cmd
);

  logic known;

  always_comb begin
    known       = 1'b1;
    enq_cmd.op  = OP_RUN;
    enq_cmd.value = item.value;
    unique case (item.func)
      FUNC_PUSH_A: enq_cmd.op = OP_PUSH_A;
      FUNC_PUSH_B: enq_cmd.op = OP_PUSH_B;
      FUNC_RUN:    enq_cmd.op = OP_RUN;
      default:     known = 1'b0;
    endcase
  end

  // drop unused selector codes on transfer without queueing them
  assign enq_valid  = item.valid && known;
  assign item.ready = enq_ready;

endmodule

`default_nettype wire

FILE: rtl/mtsl_queue.sv
// ----------------------------------------------------------------------------
// mtsl_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsl_queue import mtsl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enq_valid,
  output logic      enq_ready,
  input  wire cmd_t enq_cmd,
  output logic      deq_valid,
  input  wire logic deq_ready,
  output cmd_t      deq_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_enq;
  logic              do_deq;

  assign enq_ready = (fill != (QPTR_W + 1)'(QDEPTH));
  assign deq_valid = (fill != '0);
  assign deq_cmd   = slots[rd_ptr];
  assign do_enq    = enq_valid && enq_ready;
  assign do_deq    = deq_valid && deq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_enq && !do_deq) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (do_deq && !do_enq) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mtsl_back.sv
// ----------------------------------------------------------------------------
// mtsl_back
// Executes queued commands: list writes, overflow tracking and the merge.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsl_back import mtsl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       deq_valid,
  output logic            deq_ready,
  input  wire cmd_t       deq_cmd,
  mtsl_result_if.source   result
);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count_a, count_a_next;
  logic [CNT_W-1:0]         count_b, count_b_next;
  logic [CNT_W-1:0]         ia, ia_next;
  logic [CNT_W-1:0]         ib, ib_next;
  logic [CNT_W-1:0]         ia_inc, ib_inc;
  logic                     ovf, ovf_next;
  logic                     out_valid, out_valid_next;
  logic signed [DATA_W-1:0] out_value, out_value_next;
  logic                     out_last, out_last_next;
  logic                     out_ovf, out_ovf_next;

  logic                     we_a, we_b;
  logic signed [DATA_W-1:0] head_a, head_b;
  logic                     a_left, b_left, take_a, can_load, fin;

  // read address follows the next index, so the RAM output is always the head
  mtsl_ram #(.Width(DATA_W), .Depth(DEPTH)) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (deq_cmd.value),
    .raddr (ia_next[ADDR_W-1:0]),
    .rdata (head_a)
  );

  mtsl_ram #(.Width(DATA_W), .Depth(DEPTH)) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (deq_cmd.value),
    .raddr (ib_next[ADDR_W-1:0]),
    .rdata (head_b)
  );

  assign ia_inc   = ia + CNT_W'(1);
  assign ib_inc   = ib + CNT_W'(1);
  assign a_left   = (ia < count_a);
  assign b_left   = (ib < count_b);
  assign take_a   = a_left && (!b_left || (head_a <= head_b));
  assign can_load = !out_valid || result.ready;

  always_comb begin
    state_next     = state;
    count_a_next   = count_a;
    count_b_next   = count_b;
    ia_next        = ia;
    ib_next        = ib;
    ovf_next       = ovf;
    out_valid_next = out_valid && !result.ready;
    out_value_next = out_value;
    out_last_next  = out_last;
    out_ovf_next   = out_ovf;
    deq_ready      = 1'b0;
    we_a           = 1'b0;
    we_b           = 1'b0;
    fin            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        deq_ready = 1'b1;
        if (deq_valid) begin
          unique case (deq_cmd.op)
            OP_PUSH_A: begin
              if (count_a < CNT_W'(DEPTH)) begin
                we_a         = 1'b1;
                count_a_next = count_a + CNT_W'(1);
              end else begin
                ovf_next = 1'b1;
              end
            end
            OP_PUSH_B: begin
              if (count_b < CNT_W'(DEPTH)) begin
                we_b         = 1'b1;
                count_b_next = count_b + CNT_W'(1);
              end else begin
                ovf_next = 1'b1;
              end
            end
            OP_RUN: begin
              // empty run: keep everything, emit nothing
              if (count_a != '0 || count_b != '0) begin
                state_next = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          out_ovf_next   = ovf;
          if (take_a) begin
            out_value_next = head_a;
            ia_next        = ia_inc;
            fin            = (ia_inc == count_a) && !b_left;
          end else begin
            out_value_next = head_b;
            ib_next        = ib_inc;
            fin            = !a_left && (ib_inc == count_b);
          end
          out_last_next = fin;
          if (fin) begin
            state_next   = ST_IDLE;
            count_a_next = '0;
            count_b_next = '0;
            ovf_next     = 1'b0;
            ia_next      = '0;
            ib_next      = '0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      ia        <= '0;
      ib        <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count_a   <= count_a_next;
      count_b   <= count_b_next;
      ia        <= ia_next;
      ib        <= ib_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
    out_value <= out_value_next;
    out_last  <= out_last_next;
    out_ovf   <= out_ovf_next;
  end

  assign result.valid        = out_valid;
  assign result.merged_value = out_value;
  assign result.last         = out_last;
  assign result.overflow     = out_ovf;

endmodule

`default_nettype wire

FILE: rtl/merge_two_sorted_lists.sv
// ----------------------------------------------------------------------------
// merge_two_sorted_lists
// Two-way merge of two sorted lists held in on-chip RAM.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          transfer when
//  item     in   func[1:0], value[31:0] signed    valid && ready
//  result   out  merged_value[31:0], last, ovf    valid && ready
//
//  A push is executed in the back end while it is idle; the two-entry command queue
//  lets the front keep taking items while a merge runs.
//  A run merges both lists in order; the registered RAM read port is addressed
//  with the next index, so its output always holds the current list heads.
//  Result stalls hold the merge in place; the next value loads on transfer.
//  Synchronous reset empties the queue, both lists and the overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_two_sorted_lists import mtsl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  mtsl_item_if.sink     item,
  mtsl_result_if.source result
);

  logic enq_valid, enq_ready;
  cmd_t enq_cmd;
  logic deq_valid, deq_ready;
  cmd_t deq_cmd;

  mtsl_front u_front (
    .item      (item),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_cmd   (enq_cmd)
  );

  mtsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_cmd   (enq_cmd),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_cmd   (deq_cmd)
  );

  mtsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_cmd   (deq_cmd),
    .result    (result)
  );

endmodule

`default_nettype wire

FILE: rtl/mtsl_checker.sv
// ----------------------------------------------------------------------------
// mtsl_checker
// Port-level checks on the merge block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mtsl_checker import mtsl_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     item_ready,
  input wire logic                     result_valid,
  input wire logic                     result_ready,
  input wire logic signed [DATA_W-1:0] result_merged_value,
  input wire logic                     result_last,
  input wire logic                     result_overflow
);

  // a stalled result keeps its value
  `ASSERT_CLK_RST(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result_merged_value))

  // a run streams without gaps and carries one overflow mark throughout
  `ASSERT_CLK_RST(a_run_gapless, clk, rst, result_valid && result_ready && !result_last |=> result_valid && (result_overflow == $past(result_overflow)))

  // nothing comes out right after reset
  `ASSERT_CLK(a_reset_quiet, clk, rst |=> !result_valid)

  // the command queue is empty after reset, so items are taken
  `ASSERT_CLK(a_reset_ready, clk, rst |=> item_ready)

endmodule

bind merge_two_sorted_lists mtsl_checker u_mtsl_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_ready          (item.ready),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_merged_value (result.merged_value),
  .result_last         (result.last),
  .result_overflow     (result.overflow)
);

`default_nettype wire

FILE: bench/tb_merge_two_sorted_lists.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_merge_two_sorted_lists
// Self-checking bench for the sorted-list merge block. Pushes values into
// both lists and issues run commands under random idling on both channels.
// A scoreboard holds its own copy of the lists, predicts each merged
// sequence and checks every result transfer against it in order.
// ----------------------------------------------------------------------------
module tb_merge_two_sorted_lists;
  import mtsl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;  // unused selector, ignored
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam word_t WORD_MAX = 32'h7fff_ffff;

  typedef struct {
    word_t value;
    logic  last;
    logic  overflow;
  } merged_t;

  class merge_scoreboard;
    word_t   held_a[DEPTH];
    word_t   held_b[DEPTH];
    int      fill_a;
    int      fill_b;
    bit      dropped;
    merged_t pending_merged[$];
    int      errors;

    function new();
      fill_a  = 0;
      fill_b  = 0;
      dropped = 1'b0;
      errors  = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Apply one accepted item and queue the merged values it produces.
    function void record_item(logic [FUNC_W-1:0] func, word_t value);
      int      ia;
      int      ib;
      merged_t m;
      case (func)
        FUNC_PUSH_A: begin
          if (fill_a < DEPTH) begin
            held_a[fill_a] = value;
            fill_a++;
          end else begin
            dropped = 1'b1;
          end
        end
        FUNC_PUSH_B: begin
          if (fill_b < DEPTH) begin
            held_b[fill_b] = value;
            fill_b++;
          end else begin
            dropped = 1'b1;
          end
        end
        FUNC_RUN: begin
          // an empty run leaves everything, the overflow flag included
          if (fill_a + fill_b > 0) begin
            ia = 0;
            ib = 0;
            while (ia < fill_a || ib < fill_b) begin
              // head of A wins ties
              if (ia < fill_a && (ib >= fill_b || held_a[ia] <= held_b[ib])) begin
                m.value = held_a[ia];
                ia++;
              end else begin
                m.value = held_b[ib];
                ib++;
              end
              m.last     = (ia + ib == fill_a + fill_b);
              m.overflow = dropped;
              pending_merged.push_back(m);
            end
            fill_a  = 0;
            fill_b  = 0;
            dropped = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    task check_output(word_t value, logic last, logic overflow);
      merged_t m;
      if (pending_merged.size() == 0) begin
        report($sformatf("unexpected result value=%0d last=%b ovf=%b",
                         value, last, overflow));
        return;
      end
      m = pending_merged.pop_front();
      if (value !== m.value)
        report($sformatf("merged_value got %0d want %0d", value, m.value));
      if (last !== m.last)
        report($sformatf("last got %b want %b (value %0d)", last, m.last, m.value));
      if (overflow !== m.overflow)
        report($sformatf("overflow got %b want %b (value %0d)",
                         overflow, m.overflow, m.value));
    endtask
  endclass

  logic clk;
  logic rst;

  mtsl_item_if   item_ch ();
  mtsl_result_if result_ch ();

  merge_scoreboard merges = new();

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int quiet_cycles;

  merge_two_sorted_lists dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check each transfer, then pick ready for the next cycle.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        merges.check_output(result_ch.merged_value, result_ch.last,
                            result_ch.overflow);
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) ||
          (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[merge_two_sorted_lists] ERROR");
    $finish;
  end

  task automatic send_item(logic [FUNC_W-1:0] func, word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.func  <= func;
    item_ch.value <= value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    merges.record_item(func, value);
    items_sent++;
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 5);
    if (r < 85) return $urandom_range(6, DEPTH);
    return $urandom_range(DEPTH, DEPTH + 3);  // full, or pushes that get dropped
  endfunction

  function automatic void fill_list(ref word_t q[$], input int n, input bit unsorted);
    bit    narrow;
    word_t base;
    int    r;
    narrow = ($urandom_range(99) < 30);
    base   = $urandom;
    q.delete();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 4)      q.push_back(WORD_MIN);
      else if (r < 8) q.push_back(WORD_MAX);
      else if (r < 10) q.push_back('0);
      else if (narrow) q.push_back(base + word_t'($urandom_range(0, 3)));  // ties
      else            q.push_back($urandom);
    end
    if (!unsorted) q.sort();
  endfunction

  // One batch: two lists interleaved, some noise, then usually a run.
  task automatic send_merge_batch();
    word_t qa[$];
    word_t qb[$];
    fill_list(qa, pick_count(), $urandom_range(99) < 8);
    fill_list(qb, pick_count(), $urandom_range(99) < 8);
    while (qa.size() != 0 || qb.size() != 0) begin
      if ($urandom_range(99) < 4)
        send_item(FUNC_IDLE, $urandom);
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 1))
        send_item(FUNC_PUSH_A, qa.pop_front());
      else
        send_item(FUNC_PUSH_B, qb.pop_front());
    end
    // now and then skip the run so the lists carry over and fill up
    if ($urandom_range(99) < 90)
      send_item(FUNC_RUN, $urandom);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_merge_batch();
  endtask

  initial begin
    rst            = 1'b1;
    item_ch.valid  = 1'b0;
    item_ch.func   = FUNC_PUSH_A;
    item_ch.value  = '0;
    send_idle_pct  = 14;
    recv_stall_pct = 87;
    items_sent     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes in both lists, A and B share the minimum: A wins the tie
    send_item(FUNC_PUSH_A, WORD_MIN);
    send_item(FUNC_PUSH_A, -32'sd1);
    send_item(FUNC_PUSH_A, '0);
    send_item(FUNC_PUSH_A, WORD_MAX);
    send_item(FUNC_PUSH_B, WORD_MIN);
    send_item(FUNC_PUSH_B, '0);
    send_item(FUNC_PUSH_B, WORD_MAX);
    send_item(FUNC_RUN, '1);
    // run with both lists empty emits nothing
    send_item(FUNC_RUN, '0);
    // unused selector is ignored
    send_item(FUNC_IDLE, '1);
    send_item(FUNC_IDLE, '0);
    // only one list holds values
    send_item(FUNC_PUSH_B, 32'sd42);
    send_item(FUNC_RUN, $urandom);
    send_item(FUNC_PUSH_A, -32'sd7);
    send_item(FUNC_RUN, $urandom);
    // unsorted list A merged as it stands
    send_item(FUNC_PUSH_A, 32'sd9);
    send_item(FUNC_PUSH_A, 32'sd2);
    send_item(FUNC_PUSH_B, 32'sd5);
    send_item(FUNC_RUN, $urandom);

    run_phase(14, 87, 140);
    run_phase(87, 14, 140);
    run_phase(0, 0, 150);
    item_ch.valid <= 1'b0;

    while (merges.pending_merged.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (merges.errors == 0)
      $display("[merge_two_sorted_lists] OK");
    else
      $display("[merge_two_sorted_lists] ERROR");
    $finish;
  end

endmodule
